/* rtl/marching_squares_cell_classifier_core_defines.svh */
// Assertion macros for the marching squares cell classifier core.
`ifndef MARCHING_SQUARES_CELL_CLASSIFIER_CORE_DEFINES_SVH
`define MARCHING_SQUARES_CELL_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define MSQC_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define MSQC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define MSQC_ASSERT_ALWAYS(lbl, expr, msg)
`define MSQC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

/* rtl/msqc_pkg.sv */
// Shared types and constants of the marching squares cell classifier.
package msqc_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_THRESHOLD_SIGMA  = 2'd0;
   localparam logic [1:0] CSR_CELLS_PER_ROW    = 2'd1;
   localparam logic [1:0] CSR_CELLS_PER_COLUMN = 2'd2;

   localparam logic [7:0] SIGMA_RESET = 8'd200;
   localparam logic [8:0] CELLS_RESET = 9'd256;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // one classified sample point on its way to the back end
   typedef struct packed {
      logic       above;
      logic       pt_bit;
      logic       emit;
      logic       frame_end;
      logic [7:0] cell_row;
      logic [7:0] cell_col;
   } cell_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* rtl/msqc_front.sv */
// Front end: accepts sample points, thresholds them, tracks position, keeps the line buffer.
module msqc_front #(
   parameter int MAX_CELLS_ACROSS = 256,
   parameter int MAX_CELLS_DOWN   = 256,
   localparam int ACC_W  = $clog2(MAX_CELLS_ACROSS + 1),
   localparam int DN_W   = $clog2(MAX_CELLS_DOWN + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_red,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_blue,
   input  logic [7:0]               sigma,
   input  logic [ACC_W-1:0]         cols_lim,
   input  logic [DN_W-1:0]          rows_lim,
   input  msqc_pkg::queue_status_type q_stat,
   output logic                     ent_valid,
   output msqc_pkg::cell_entry_type ent
);

   localparam int FILL_W = $clog2(MAX_CELLS_ACROSS + 2);
   localparam int DEPTH  = MAX_CELLS_ACROSS + 1;

   logic [ACC_W-1:0]  col_ff, col_in;
   logic [DN_W-1:0]   row_ff, row_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              stage_valid_ff, stage_valid_in;
   msqc_pkg::cell_entry_type stage_ff, stage_in;
   logic              line_rd_ff;
   logic              line_mem [DEPTH];

   logic        accept;
   logic [9:0]  sum;
   logic [9:0]  thr;
   logic        row_end;
   logic        frame_end;
   logic        pt_bit;
   logic [31:0] row_m1;
   logic [31:0] col_m1;

   assign req_stall = stage_valid_ff && q_stat.full;
   assign accept    = req_valid && !req_stall;

   // mean <= sigma  <=>  sum < 3*sigma + 3
   assign sum       = 10'(req_red) + 10'(req_green) + 10'(req_blue);
   assign thr       = 10'(sigma) * 10'd3 + 10'd3;
   assign row_end   = col_ff >= cols_lim;
   assign frame_end = row_end && (row_ff >= rows_lim);
   assign pt_bit    = !frame_end && (sum < thr);
   assign row_m1    = 32'(row_ff) - 32'd1;
   assign col_m1    = 32'(col_ff) - 32'd1;

   always_comb begin
      col_in         = col_ff;
      row_in         = row_ff;
      fill_in        = fill_ff;
      stage_in       = stage_ff;
      stage_valid_in = accept || (stage_valid_ff && q_stat.full);
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + DN_W'(1);
         end else begin
            col_in = col_ff + ACC_W'(1);
         end
         // line buffer is always written from entry 0 upward, so a fill count marks valid data
         if (32'(col_ff) == 32'(fill_ff)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
         stage_in.above     = 32'(col_ff) < 32'(fill_ff);
         stage_in.pt_bit    = pt_bit;
         stage_in.emit      = (row_ff != '0) && (col_ff != '0);
         stage_in.frame_end = frame_end;
         stage_in.cell_row  = row_m1[7:0];
         stage_in.cell_col  = col_m1[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         fill_ff        <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         fill_ff        <= fill_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   // read-before-write on the same entry: the read returns the upper row's bit
   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[col_ff] <= pt_bit;
         line_rd_ff       <= line_mem[col_ff];
      end
   end

   always_comb begin
      ent       = stage_ff;
      ent.above = stage_ff.above && line_rd_ff;
   end
   assign ent_valid = stage_valid_ff;

endmodule

/* rtl/msqc_queue.sv */
// Short queue between the front and back ends.
module msqc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  msqc_pkg::cell_entry_type   push_data,
   input  logic                       pop,
   output logic                       head_valid,
   output msqc_pkg::cell_entry_type   head,
   output msqc_pkg::queue_status_type q_stat
);

   logic [msqc_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [msqc_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [msqc_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   msqc_pkg::cell_entry_type         slot_ff [msqc_pkg::QUEUE_DEPTH];
   logic push;
   logic do_pop;

   assign q_stat.full  = count_ff == msqc_pkg::QUEUE_CNT_W'(msqc_pkg::QUEUE_DEPTH);
   assign q_stat.empty = count_ff == '0;
   assign push         = push_valid && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head_valid   = !q_stat.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + msqc_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + msqc_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + msqc_pkg::QUEUE_CNT_W'(push) - msqc_pkg::QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/msqc_back.sv */
// Back end: forms the cell case index from neighbor bits and holds the result beat.
module msqc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  msqc_pkg::cell_entry_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [3:0]               rsp_case_index,
   output logic [7:0]               rsp_cell_row,
   output logic [7:0]               rsp_cell_col,
   output logic                     rsp_frame_done
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic       left_ff, left_in;
   logic       upper_left_ff, upper_left_in;
   logic [3:0] case_ff, case_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] col_ff, col_in;
   logic       done_ff, done_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head_valid && out_free;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      left_in       = left_ff;
      upper_left_in = upper_left_ff;
      case_in       = case_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      done_in       = done_ff;
      if (out_free) begin
         rsp_valid_in = pop && head.emit;
      end
      if (pop) begin
         upper_left_in = head.above;
         left_in       = head.pt_bit;
         case_in       = {upper_left_ff, head.above, head.pt_bit, left_ff};
         row_in        = head.cell_row;
         col_in        = head.cell_col;
         done_in       = head.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         left_ff       <= 1'b0;
         upper_left_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         left_ff       <= left_in;
         upper_left_ff <= upper_left_in;
      end
   end

   always_ff @(posedge clock) begin
      case_ff <= case_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      done_ff <= done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_case_index = case_ff;
   assign rsp_cell_row   = row_ff;
   assign rsp_cell_col   = col_ff;
   assign rsp_frame_done = done_ff;

endmodule

/* rtl/marching_squares_cell_classifier_core.sv */
// Marching squares cell classifier: top level with configuration registers.
// Throughput one sample point per cycle while req_stall is low; the line buffer takes one read and one write per beat.
// A point passes the front stage register, the queue and the back end's result register before its beat shows on rsp.
// Reset: position, line buffer fill count, queue and output cleared; registers to defaults.
// The line buffer itself is not cleared; entries past the fill count read as zero.
`include "marching_squares_cell_classifier_core_defines.svh"
module marching_squares_cell_classifier_core #(
   parameter int MAX_CELLS_ACROSS = 256,
   parameter int MAX_CELLS_DOWN   = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_case_index,
   output logic [7:0] rsp_cell_row,
   output logic [7:0] rsp_cell_col,
   output logic       rsp_frame_done,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_data
);

   localparam int ACC_W = $clog2(MAX_CELLS_ACROSS + 1);
   localparam int DN_W  = $clog2(MAX_CELLS_DOWN + 1);

   logic [7:0] sigma_ff, sigma_in;
   logic [8:0] cols_cfg_ff, cols_cfg_in;
   logic [8:0] rows_cfg_ff, rows_cfg_in;

   logic [ACC_W-1:0] cols_lim;
   logic [DN_W-1:0]  rows_lim;

   logic                       ent_valid;
   msqc_pkg::cell_entry_type   ent;
   logic                       pop;
   logic                       head_valid;
   msqc_pkg::cell_entry_type   head;
   msqc_pkg::queue_status_type q_stat;

   always_comb begin
      sigma_in    = sigma_ff;
      cols_cfg_in = cols_cfg_ff;
      rows_cfg_in = rows_cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            msqc_pkg::CSR_THRESHOLD_SIGMA:  sigma_in    = csr_data[7:0];
            msqc_pkg::CSR_CELLS_PER_ROW:    cols_cfg_in = csr_data;
            msqc_pkg::CSR_CELLS_PER_COLUMN: rows_cfg_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff    <= msqc_pkg::SIGMA_RESET;
         cols_cfg_ff <= msqc_pkg::CELLS_RESET;
         rows_cfg_ff <= msqc_pkg::CELLS_RESET;
      end else begin
         sigma_ff    <= sigma_in;
         cols_cfg_ff <= cols_cfg_in;
         rows_cfg_ff <= rows_cfg_in;
      end
   end

   // zero counts as one cell, oversize saturates to the buffer size
   always_comb begin
      if (cols_cfg_ff == '0) begin
         cols_lim = ACC_W'(1);
      end else if (32'(cols_cfg_ff) > MAX_CELLS_ACROSS) begin
         cols_lim = ACC_W'(MAX_CELLS_ACROSS);
      end else begin
         cols_lim = ACC_W'(cols_cfg_ff);
      end
      if (rows_cfg_ff == '0) begin
         rows_lim = DN_W'(1);
      end else if (32'(rows_cfg_ff) > MAX_CELLS_DOWN) begin
         rows_lim = DN_W'(MAX_CELLS_DOWN);
      end else begin
         rows_lim = DN_W'(rows_cfg_ff);
      end
   end

   msqc_front #(
      .MAX_CELLS_ACROSS(MAX_CELLS_ACROSS),
      .MAX_CELLS_DOWN  (MAX_CELLS_DOWN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_red  (req_red),
      .req_green(req_green),
      .req_blue (req_blue),
      .sigma    (sigma_ff),
      .cols_lim (cols_lim),
      .rows_lim (rows_lim),
      .q_stat   (q_stat),
      .ent_valid(ent_valid),
      .ent      (ent)
   );

   msqc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(ent_valid),
      .push_data (ent),
      .pop       (pop),
      .head_valid(head_valid),
      .head      (head),
      .q_stat    (q_stat)
   );

   msqc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_case_index(rsp_case_index),
      .rsp_cell_row  (rsp_cell_row),
      .rsp_cell_col  (rsp_cell_col),
      .rsp_frame_done(rsp_frame_done)
   );

   `MSQC_ASSERT_ALWAYS(a_queue_full_empty, !(q_stat.full && q_stat.empty), "queue full and empty")
   `MSQC_ASSERT_IMPL(a_rsp_from_queue, $rose(rsp_valid), $past(head_valid), "beat without entry")
   `MSQC_ASSERT_IMPL(a_ready_after_reset, $past(reset), !req_stall, "stall right after reset")

endmodule
